@@ rtl/tblj_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tblj_pkg: shared types and constants for the tree jump engine
// Sizes, request and status codes, and the one-hot sequencer states.
// ----------------------------------------------------------------------------
package tblj_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int NODE_W      = 10;
  localparam int CNT_W       = 11;
  localparam int LIFT_LEVELS = 11;
  localparam int LVL_W       = 4;
  localparam int EDGE_CAP    = 2 * MAX_NODES - 2;
  localparam int LIFT_DEPTH  = LIFT_LEVELS * MAX_NODES;
  localparam int LIFT_AW     = LVL_W + NODE_W;

  localparam logic [CNT_W-1:0] NO_EDGE   = 11'h7FF;
  localparam logic [CNT_W-1:0] UNREACHED = 11'h7FF;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_BUILD = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_NODE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NO_BUILD = 2'd3;

  typedef enum logic [31:0] {
    S_CLEAR  = 32'h0000_0001,
    S_IDLE   = 32'h0000_0002,
    S_E1     = 32'h0000_0004,
    S_E2     = 32'h0000_0008,
    S_E3     = 32'h0000_0010,
    S_E4     = 32'h0000_0020,
    S_B_INIT = 32'h0000_0040,
    S_B_ROOT = 32'h0000_0080,
    S_B_POP  = 32'h0000_0100,
    S_B_V    = 32'h0000_0200,
    S_B_H    = 32'h0000_0400,
    S_B_E    = 32'h0000_0800,
    S_B_T    = 32'h0000_1000,
    S_B_U    = 32'h0000_2000,
    S_L_A    = 32'h0000_4000,
    S_L_B    = 32'h0000_8000,
    S_L_C    = 32'h0001_0000,
    S_Q_DA   = 32'h0002_0000,
    S_Q_DB   = 32'h0004_0000,
    S_Q_CHK  = 32'h0008_0000,
    S_C_A    = 32'h0010_0000,
    S_C_B    = 32'h0020_0000,
    S_Q_EQ   = 32'h0040_0000,
    S_M_A    = 32'h0080_0000,
    S_M_B    = 32'h0100_0000,
    S_M_C    = 32'h0200_0000,
    S_M_F    = 32'h0400_0000,
    S_M_G    = 32'h0800_0000,
    S_Q_DANC = 32'h1000_0000,
    S_Q_PL   = 32'h2000_0000,
    S_Q_K    = 32'h4000_0000,
    S_Q_END  = 32'h8000_0000
  } state_t;

endpackage

@@ rtl/tree_binary_lifting_jump.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_binary_lifting_jump: binary-lifting tree path engine
// Stores edges, builds parent/depth and a 2^k ancestor table from a root,
// and answers LCA, distance and k-th path node queries.
// ----------------------------------------------------------------------------
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------
//  request   | start / busy         | req_type, node_a, node_b, step_count
//  result    | done (1-cycle strobe)| status, found, jump_node,
//            |                      | common_ancestor, path_length
//  config    | cfg_write            | cfg_data (node_count)
//
//  A build runs a depth/parent init over all 1024 nodes, a stack walk over
//  the reached nodes and the edge entries they hold, then the table fill of
//  10 levels over 1024 nodes; a query's time is set by the single read port
//  of the lift table (each climb steps through 11 levels one read at a time,
//  as does the meet loop).
//  After reset a clearing pass over all 1024 nodes empties the edge chains and
//  marks all nodes unreached; busy stays high through it.
//  One request at a time: busy rises the cycle after a multi-cycle request is
//  accepted and falls in the cycle where done is high; a request rejected at
//  acceptance gives done the next cycle and never raises busy.
//  The receiver cannot stall; each result is valid for one cycle.
//
module tree_binary_lifting_jump
  import tblj_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        req_type,
  input  logic [NODE_W-1:0] node_a,
  input  logic [NODE_W-1:0] node_b,
  input  logic [CNT_W-1:0]  step_count,
  output logic              done,
  output logic [1:0]        status,
  output logic              found,
  output logic [NODE_W-1:0] jump_node,
  output logic [NODE_W-1:0] common_ancestor,
  output logic [CNT_W-1:0]  path_length,
  input  logic              cfg_write,
  input  logic [CNT_W-1:0]  cfg_data
);

  state_t state;
  state_t cret;

  // control
  logic [CNT_W-1:0]  node_count;
  logic              ready;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  sp;
  logic [NODE_W-1:0] idx;
  logic [LVL_W-1:0]  lvl;

  // latched request and work registers
  logic [NODE_W-1:0] ra, rb;
  logic [CNT_W-1:0]  rk;
  logic [NODE_W-1:0] bv, bu;
  logic [CNT_W-1:0]  be, bdv;
  logic [NODE_W-1:0] cv, ov, pu, anc;
  logic [CNT_W-1:0]  ck, da, db, ups, plen;

  // memories
  logic [NODE_W-1:0] tgt_mem   [0:EDGE_CAP-1];
  logic [CNT_W-1:0]  link_mem  [0:EDGE_CAP-1];
  logic [CNT_W-1:0]  head_mem  [0:MAX_NODES-1];
  logic [CNT_W-1:0]  depth_mem [0:MAX_NODES-1];
  logic [NODE_W-1:0] stack_mem [0:MAX_NODES-1];
  logic [NODE_W-1:0] lift_mem  [0:LIFT_DEPTH-1];

  logic [NODE_W-1:0] tgt_q, stack_q, lift_q;
  logic [CNT_W-1:0]  link_q, head_q, depth_q;

  logic              edge_we, head_we, depth_we, stack_we, lift_we;
  logic [CNT_W-1:0]  edge_waddr, edge_raddr;
  logic [NODE_W-1:0] edge_wtgt;
  logic [CNT_W-1:0]  edge_wlink;
  logic [NODE_W-1:0] head_waddr, head_raddr;
  logic [CNT_W-1:0]  head_wdata;
  logic [NODE_W-1:0] depth_waddr, depth_raddr;
  logic [CNT_W-1:0]  depth_wdata;
  logic [NODE_W-1:0] stack_waddr, stack_raddr, stack_wdata;
  logic [LIFT_AW-1:0] lift_waddr, lift_raddr;
  logic [NODE_W-1:0] lift_wdata;

  logic              u_new;
  logic [CNT_W-1:0]  cfg_clamped;
  logic [CNT_W-1:0]  anc_up_s, anc_up_t;

  assign busy  = (state != S_IDLE);
  // a popped neighbor is taken only if in range and not yet reached
  assign u_new = ({1'b0, bu} < node_count) && (depth_q == UNREACHED);
  assign cfg_clamped = (cfg_data == '0) ? CNT_W'(1) :
                       (cfg_data > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : cfg_data;
  assign anc_up_s = da - depth_q;
  assign anc_up_t = db - depth_q;

  // --------------------------------------------------------------------------
  // Memory address and write selection per sequencer state
  // --------------------------------------------------------------------------
  always_comb begin
    edge_we = 1'b0; head_we = 1'b0; depth_we = 1'b0; stack_we = 1'b0; lift_we = 1'b0;
    edge_waddr = fill; edge_raddr = be; edge_wtgt = rb; edge_wlink = head_q;
    head_waddr = ra; head_raddr = ra; head_wdata = fill;
    depth_waddr = idx; depth_raddr = ra; depth_wdata = UNREACHED;
    stack_waddr = sp[NODE_W-1:0]; stack_raddr = sp[NODE_W-1:0] - NODE_W'(1);
    stack_wdata = bu;
    lift_waddr = {LVL_W'(0), idx}; lift_raddr = {lvl, cv}; lift_wdata = idx;
    case (state)
      S_CLEAR: begin
        head_we = 1'b1; head_waddr = idx; head_wdata = NO_EDGE;
        depth_we = 1'b1;
      end
      S_E1: head_raddr = ra;
      S_E2: begin
        edge_we = 1'b1; edge_wtgt = rb;
        head_we = 1'b1; head_waddr = ra;
      end
      S_E3: head_raddr = rb;
      S_E4: begin
        edge_we = 1'b1; edge_wtgt = ra;
        head_we = 1'b1; head_waddr = rb;
      end
      S_B_INIT: begin
        depth_we = 1'b1;
        lift_we = 1'b1;
      end
      S_B_ROOT: begin
        depth_we = 1'b1; depth_waddr = ra; depth_wdata = '0;
        stack_we = 1'b1; stack_waddr = '0; stack_wdata = ra;
      end
      S_B_V: begin
        head_raddr = stack_q;
        depth_raddr = stack_q;
      end
      S_B_T: depth_raddr = tgt_q;
      S_B_U: begin
        depth_we = u_new; depth_waddr = bu; depth_wdata = bdv + CNT_W'(1);
        stack_we = u_new;
        lift_we = u_new; lift_waddr = {LVL_W'(0), bu}; lift_wdata = bv;
      end
      S_L_A: lift_raddr = {lvl, idx};
      S_L_B: lift_raddr = {lvl, lift_q};
      S_L_C: begin
        lift_we = 1'b1; lift_waddr = {lvl + LVL_W'(1), idx}; lift_wdata = lift_q;
      end
      S_Q_DA: depth_raddr = ra;
      S_Q_DB: depth_raddr = rb;
      S_C_A: lift_raddr = {lvl, cv};
      S_M_A: lift_raddr = {lvl, cv};
      S_M_B: lift_raddr = {lvl, ov};
      S_M_F: lift_raddr = {LVL_W'(0), cv};
      S_Q_DANC: depth_raddr = anc;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      tgt_mem[edge_waddr]  <= edge_wtgt;
      link_mem[edge_waddr] <= edge_wlink;
    end
    tgt_q  <= tgt_mem[edge_raddr];
    link_q <= link_mem[edge_raddr];
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_q <= head_mem[head_raddr];
  end

  always_ff @(posedge clk) begin
    if (depth_we) begin
      depth_mem[depth_waddr] <= depth_wdata;
    end
    depth_q <= depth_mem[depth_raddr];
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    stack_q <= stack_mem[stack_raddr];
  end

  always_ff @(posedge clk) begin
    if (lift_we) begin
      lift_mem[lift_waddr] <= lift_wdata;
    end
    lift_q <= lift_mem[lift_raddr];
  end

  // --------------------------------------------------------------------------
  // Sequencer: one memory step per cycle, shared climb unit for queries
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cret       <= S_IDLE;
      node_count <= CNT_W'(MAX_NODES);
      ready      <= 1'b0;
      fill       <= '0;
      sp         <= '0;
      idx        <= '0;
      lvl        <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        node_count <= cfg_clamped;
        ready      <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          idx <= idx + NODE_W'(1);
          if (idx == NODE_W'(MAX_NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            ra <= node_a;
            rb <= node_b;
            rk <= step_count;
            status <= ST_OK; found <= 1'b0; jump_node <= '0;
            common_ancestor <= '0; path_length <= '0;
            case (req_type)
              REQ_ADD: begin
                if ({1'b0, node_a} >= node_count || {1'b0, node_b} >= node_count) begin
                  status <= ST_BAD_NODE; done <= 1'b1;
                end else if (fill > CNT_W'(EDGE_CAP - 2)) begin
                  // fewer than two free entries left
                  status <= ST_FULL; done <= 1'b1;
                end else begin
                  state <= S_E1;
                end
              end
              REQ_BUILD: begin
                if ({1'b0, node_a} >= node_count) begin
                  status <= ST_BAD_NODE; done <= 1'b1;
                end else begin
                  idx <= '0; state <= S_B_INIT;
                end
              end
              REQ_QUERY: begin
                if (!ready) begin
                  status <= ST_NO_BUILD; done <= 1'b1;
                end else if ({1'b0, node_a} >= node_count ||
                             {1'b0, node_b} >= node_count) begin
                  status <= ST_BAD_NODE; done <= 1'b1;
                end else begin
                  state <= S_Q_DA;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        // add edge: push onto the chain of each end
        S_E1: state <= S_E2;
        S_E2: begin
          fill <= fill + CNT_W'(1); state <= S_E3;
        end
        S_E3: state <= S_E4;
        S_E4: begin
          fill <= fill + CNT_W'(1); done <= 1'b1; state <= S_IDLE;
        end
        // build: reset depths and self-parents, then walk with the stack
        S_B_INIT: begin
          idx <= idx + NODE_W'(1);
          if (idx == NODE_W'(MAX_NODES - 1)) begin
            state <= S_B_ROOT;
          end
        end
        S_B_ROOT: begin
          sp <= CNT_W'(1); state <= S_B_POP;
        end
        S_B_POP: begin
          if (sp == '0) begin
            lvl <= '0; idx <= '0; state <= S_L_A;
          end else begin
            sp <= sp - CNT_W'(1); state <= S_B_V;
          end
        end
        S_B_V: begin
          bv <= stack_q; state <= S_B_H;
        end
        S_B_H: begin
          be <= head_q; bdv <= depth_q; state <= S_B_E;
        end
        S_B_E: state <= (be < fill) ? S_B_T : S_B_POP;
        S_B_T: begin
          bu <= tgt_q; be <= link_q; state <= S_B_U;
        end
        S_B_U: begin
          if (u_new) begin
            sp <= sp + CNT_W'(1);
          end
          state <= S_B_E;
        end
        // table fill: level l+1 of v is level l of level l of v
        S_L_A: state <= S_L_B;
        S_L_B: state <= S_L_C;
        S_L_C: begin
          idx <= idx + NODE_W'(1);
          state <= S_L_A;
          if (idx == NODE_W'(MAX_NODES - 1)) begin
            if (lvl == LVL_W'(LIFT_LEVELS - 2)) begin
              ready <= 1'b1; done <= 1'b1; state <= S_IDLE;
            end else begin
              lvl <= lvl + LVL_W'(1);
            end
          end
        end
        // query
        S_Q_DA: state <= S_Q_DB;
        S_Q_DB: begin
          da <= depth_q; state <= S_Q_CHK;
        end
        S_Q_CHK: begin
          db <= depth_q;
          if (da == UNREACHED || depth_q == UNREACHED) begin
            status <= ST_BAD_NODE; done <= 1'b1; state <= S_IDLE;
          end else begin
            // climb the deeper node up to the other's depth
            if (da < depth_q) begin
              cv <= rb; ov <= ra; ck <= depth_q - da;
            end else begin
              cv <= ra; ov <= rb; ck <= da - depth_q;
            end
            lvl <= '0; cret <= S_Q_EQ; state <= S_C_A;
          end
        end
        S_C_A: state <= S_C_B;
        S_C_B: begin
          if (ck[lvl]) begin
            cv <= lift_q;
          end
          if (lvl == LVL_W'(LIFT_LEVELS - 1)) begin
            state <= cret;
          end else begin
            lvl <= lvl + LVL_W'(1); state <= S_C_A;
          end
        end
        S_Q_EQ: begin
          if (cv == ov) begin
            anc <= cv; state <= S_Q_DANC;
          end else begin
            lvl <= LVL_W'(LIFT_LEVELS - 1); state <= S_M_A;
          end
        end
        S_M_A: state <= S_M_B;
        S_M_B: begin
          pu <= lift_q; state <= S_M_C;
        end
        S_M_C: begin
          if (pu != lift_q) begin
            cv <= pu; ov <= lift_q;
          end
          if (lvl == '0) begin
            state <= S_M_F;
          end else begin
            lvl <= lvl - LVL_W'(1); state <= S_M_A;
          end
        end
        S_M_F: state <= S_M_G;
        S_M_G: begin
          anc <= lift_q; state <= S_Q_DANC;
        end
        S_Q_DANC: state <= S_Q_PL;
        S_Q_PL: begin
          ups  <= anc_up_s;
          plen <= anc_up_s + anc_up_t;
          state <= S_Q_K;
        end
        S_Q_K: begin
          common_ancestor <= anc;
          path_length     <= plen;
          if (rk <= plen) begin
            if (rk <= ups) begin
              cv <= ra; ck <= rk;
            end else begin
              cv <= rb; ck <= plen - rk;
            end
            lvl <= '0; cret <= S_Q_END; state <= S_C_A;
          end else begin
            done <= 1'b1; state <= S_IDLE;
          end
        end
        S_Q_END: begin
          found <= 1'b1; jump_node <= cv; done <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result strobe without a request in flight");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted request neither finished nor in progress");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (status == ST_OK))
    else $error("found set on an error result");

  a_jump_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (jump_node == '0))
    else $error("jump node nonzero without found");

endmodule

@@ tb/tblj_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tblj_checker: request/result predictor and scoreboard for the tree engine
// Mirrors edge chains, depths and the ancestor table, predicts one result per
// accepted request and compares it field by field with each done strobe.
// ----------------------------------------------------------------------------
module tblj_checker
  import tblj_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        req_type,
  input  logic [NODE_W-1:0] node_a,
  input  logic [NODE_W-1:0] node_b,
  input  logic [CNT_W-1:0]  step_count,
  input  logic              done,
  input  logic [1:0]        status,
  input  logic              found,
  input  logic [NODE_W-1:0] jump_node,
  input  logic [NODE_W-1:0] common_ancestor,
  input  logic [CNT_W-1:0]  path_length,
  input  logic              cfg_write,
  input  logic [CNT_W-1:0]  cfg_data,
  output int                errors,
  output int                pending,
  output int                checked
);

  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [NODE_W-1:0] jump;
    logic [NODE_W-1:0] anc;
    logic [CNT_W-1:0]  plen;
  } answer_t;

  answer_t answer_q[$];

  int edge_to   [EDGE_CAP];
  int edge_next [EDGE_CAP];
  int head      [MAX_NODES];
  int fill;
  int depth     [MAX_NODES];   // -1 marks unreached
  int anc_tab   [LIFT_LEVELS][MAX_NODES];
  int stack_mem [MAX_NODES];
  bit ready;
  int nodes;

  function automatic int climb_up(int v, int k);
    for (int l = 0; l < LIFT_LEVELS && k != 0; l++) begin
      if (k & 1) v = anc_tab[l][v];
      k = k >> 1;
    end
    return v;
  endfunction

  function automatic int lowest_common(int u, int v);
    int x;
    if (depth[u] < depth[v]) begin
      x = u; u = v; v = x;
    end
    u = climb_up(u, depth[u] - depth[v]);
    if (u == v) return u;
    for (int l = LIFT_LEVELS - 1; l >= 0; l--) begin
      if (anc_tab[l][u] != anc_tab[l][v]) begin
        u = anc_tab[l][u];
        v = anc_tab[l][v];
      end
    end
    return anc_tab[0][u];
  endfunction

  function automatic void walk_tree(int root);
    int sp, v, e, u;
    sp = 0;
    for (int i = 0; i < MAX_NODES; i++) begin
      depth[i] = -1;
      anc_tab[0][i] = i;
    end
    depth[root] = 0;
    stack_mem[sp] = root;
    sp = sp + 1;
    while (sp > 0) begin
      sp = sp - 1;
      v = stack_mem[sp];
      e = head[v];
      while (e >= 0 && e < fill) begin
        u = edge_to[e];
        if (u < nodes && depth[u] < 0 && sp < MAX_NODES) begin
          anc_tab[0][u] = v;
          depth[u] = depth[v] + 1;
          stack_mem[sp] = u;
          sp = sp + 1;
        end
        e = edge_next[e];
      end
    end
    for (int l = 1; l < LIFT_LEVELS; l++)
      for (int i = 0; i < MAX_NODES; i++)
        anc_tab[l][i] = anc_tab[l-1][anc_tab[l-1][i]];
    ready = 1;
  endfunction

  function automatic answer_t predict_path(logic [1:0] rt, int a, int b, int k);
    answer_t r;
    int m, up_s, up_t, pl;
    r = '0;
    case (rt)
      REQ_ADD: begin
        if (a >= nodes || b >= nodes) r.status = ST_BAD_NODE;
        else if (fill + 2 > EDGE_CAP) r.status = ST_FULL;
        else begin
          edge_to[fill] = b; edge_next[fill] = head[a]; head[a] = fill; fill++;
          edge_to[fill] = a; edge_next[fill] = head[b]; head[b] = fill; fill++;
        end
      end
      REQ_BUILD: begin
        if (a >= nodes) r.status = ST_BAD_NODE;
        else walk_tree(a);
      end
      REQ_QUERY: begin
        if (!ready) r.status = ST_NO_BUILD;
        else if (a >= nodes || b >= nodes || depth[a] < 0 || depth[b] < 0)
          r.status = ST_BAD_NODE;
        else begin
          m = lowest_common(a, b);
          up_s = depth[a] - depth[m];
          up_t = depth[b] - depth[m];
          pl = up_s + up_t;
          r.anc = NODE_W'(m);
          r.plen = CNT_W'(pl);
          if (k <= pl) begin
            r.found = 1'b1;
            r.jump = (k <= up_s) ? NODE_W'(climb_up(a, k)) : NODE_W'(climb_up(b, pl - k));
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [CNT_W-1:0] exp_v, logic [CNT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    answer_t e;
    int v;
    if (rst) begin
      answer_q.delete();
      for (int i = 0; i < MAX_NODES; i++) begin
        head[i] = -1;
        depth[i] = -1;
      end
      fill = 0;
      ready = 0;
      nodes = MAX_NODES;
      errors = 0;
      checked = 0;
    end else begin
      // results first: a done never belongs to a request taken this same edge
      if (done) begin
        if (answer_q.size() == 0) begin
          $display("%0t: result with no request outstanding", $time);
          errors++;
        end else begin
          e = answer_q.pop_front();
          check_field("status", CNT_W'(e.status), CNT_W'(status));
          check_field("found", CNT_W'(e.found), CNT_W'(found));
          check_field("jump_node", CNT_W'(e.jump), CNT_W'(jump_node));
          check_field("common_ancestor", CNT_W'(e.anc), CNT_W'(common_ancestor));
          check_field("path_length", e.plen, path_length);
          checked++;
        end
      end
      if (cfg_write) begin
        v = int'(cfg_data);
        if (v == 0) v = 1;
        if (v > MAX_NODES) v = MAX_NODES;
        nodes = v;
        ready = 0;
      end
      if (start && !busy)
        answer_q.insert(answer_q.size(),
                        predict_path(req_type, int'(node_a), int'(node_b),
                                     int'(step_count)));
    end
    pending = answer_q.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the tree path engine
// Drives edge, build, path and unknown requests over several node-count settings,
// with random sender gaps; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
  import tblj_pkg::*;

  localparam logic [1:0] REQ_BAD = 2'd3;  // unknown request kind
  localparam int STALL_LIMIT = 200000;    // longest build plus clearing, several times over

  logic              clk = 0;
  logic              rst = 1;
  logic              start = 0;
  logic              busy;
  logic [1:0]        req_type = '0;
  logic [NODE_W-1:0] node_a = '0;
  logic [NODE_W-1:0] node_b = '0;
  logic [CNT_W-1:0]  step_count = '0;
  logic              done;
  logic [1:0]        status;
  logic              found;
  logic [NODE_W-1:0] jump_node;
  logic [NODE_W-1:0] common_ancestor;
  logic [CNT_W-1:0]  path_length;
  logic              cfg_write = 0;
  logic [CNT_W-1:0]  cfg_data = '0;

  int errors, pending, checked;
  int nodes = MAX_NODES;   // node count as the block sees it
  int edges_used = 0;      // undirected edges stored so far
  int settings = 0;
  int requests = 0;
  bit quiet = 0;           // no sender gaps while set
  int stall = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  tree_binary_lifting_jump DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .node_a(node_a), .node_b(node_b), .step_count(step_count),
    .done(done), .status(status), .found(found), .jump_node(jump_node),
    .common_ancestor(common_ancestor), .path_length(path_length),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  tblj_checker score (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .node_a(node_a), .node_b(node_b), .step_count(step_count),
    .done(done), .status(status), .found(found), .jump_node(jump_node),
    .common_ancestor(common_ancestor), .path_length(path_length),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .checked(checked)
  );

  // Watchdog: reset on any accepted request or result.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall <= 0;
    else stall <= stall + 1;
    if (stall > STALL_LIMIT) begin
      $display("FAIL tree_binary_lifting_jump");
      $finish;
    end
  end

  // Issue one request; called and returns at a falling edge.
  task automatic send(logic [1:0] rt, int a, int b, int k);
    req_type = rt;
    node_a = NODE_W'(a);
    node_b = NODE_W'(b);
    step_count = CNT_W'(k);
    start = 1;
    // busy only moves at rising edges, so its value here holds for the next one
    while (busy) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    requests++;
    if (rt == REQ_ADD && a < nodes && b < nodes && edges_used < EDGE_CAP / 2)
      edges_used++;
    if (!quiet && $urandom_range(0, 99) < 28) begin
      start = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // Hold the sender until every result is back, then write the register.
  task automatic set_nodes(int v);
    start = 0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_data = CNT_W'(v);
    cfg_write = 1;
    @(negedge clk);
    cfg_write = 0;
    nodes = (v == 0) ? 1 : (v > MAX_NODES ? MAX_NODES : v);
    settings++;
  endtask

  function automatic int pick_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 24);
    if (r < 85) return $urandom_range(0, 2047);
    return 0;
  endfunction

  task automatic query_any();
    int s, t;
    if ($urandom_range(0, 9) == 0) begin
      s = $urandom_range(0, 1023);
      t = $urandom_range(0, 1023);
    end else begin
      s = $urandom_range(0, nodes - 1);
      t = $urandom_range(0, nodes - 1);
    end
    send(REQ_QUERY, s, t, pick_step());
  endtask

  // Random tree of n nodes on consecutive labels from a random offset.
  task automatic add_tree(int n);
    int off;
    off = $urandom_range(0, nodes - 1);
    for (int i = 1; i < n; i++)
      send(REQ_ADD, (off + i) % nodes, (off + $urandom_range(0, i - 1)) % nodes, 0);
  endtask

  initial begin
    int n, r;
    int pick[8] = '{2, 3, 16, 100, 600, 1024, 5, 1};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // --- directed part ---
    send(REQ_QUERY, 0, 0, 0);             // no build yet
    set_nodes(8);
    send(REQ_ADD, 3, 9, 0);               // end out of range
    send(REQ_ADD, 9, 3, 0);
    send(REQ_ADD, 0, 1, 0);
    send(REQ_ADD, 0, 2, 0);
    send(REQ_ADD, 1, 3, 0);
    send(REQ_ADD, 1, 4, 0);
    send(REQ_ADD, 2, 5, 0);
    send(REQ_ADD, 5, 6, 0);
    send(REQ_ADD, 6, 7, 0);
    send(REQ_ADD, 4, 4, 0);               // self-loop
    send(REQ_ADD, 1, 0, 0);               // repeated edge
    send(REQ_BUILD, 9, 0, 0);             // root out of range
    send(REQ_QUERY, 1, 2, 0);             // still not built
    send(REQ_BUILD, 0, 0, 0);
    send(REQ_QUERY, 3, 6, 0);
    send(REQ_QUERY, 3, 6, 5);             // step lands on target
    send(REQ_QUERY, 3, 6, 6);             // step past the path
    send(REQ_QUERY, 7, 0, 3);             // k-th ancestor
    send(REQ_QUERY, 7, 0, 2047);
    send(REQ_QUERY, 4, 4, 0);
    send(REQ_QUERY, 6, 9, 0);             // target out of range
    send(REQ_BAD, 1023, 1023, 2047);
    set_nodes(0);                         // clamps to one node
    send(REQ_QUERY, 0, 0, 0);             // register write dropped the build
    send(REQ_BUILD, 0, 0, 0);
    send(REQ_QUERY, 0, 0, 1);
    set_nodes(2000);                      // clamps to the maximum
    send(REQ_BUILD, 0, 0, 0);
    send(REQ_QUERY, 1023, 0, 0);          // never reached

    // --- random phases ---
    for (int p = 0; p < 14; p++) begin
      set_nodes(p % 2 ? pick[p / 2] : $urandom_range(1, 2047));
      quiet = (p == 3);
      if (nodes >= 2) begin
        n = $urandom_range(2, nodes < 30 ? nodes : 30);
        add_tree(n);
      end
      if (nodes < MAX_NODES && $urandom_range(0, 9) == 0)
        send(REQ_BUILD, $urandom_range(nodes, 1023), 0, 0);
      send(REQ_BUILD, $urandom_range(0, nodes - 1), 0, 0);
      for (int i = 0; i < 50; i++) begin
        r = $urandom_range(0, 99);
        if (r < 80) query_any();
        else if (r < 92)
          send(REQ_ADD, $urandom_range(0, 1023), $urandom_range(0, nodes - 1), 0);
        else send(REQ_BAD, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 2047));
      end
    end
    quiet = 0;

    // --- deep chain until the edge store runs out ---
    set_nodes(MAX_NODES);
    n = 0;
    while (edges_used < EDGE_CAP / 2) begin
      send(REQ_ADD, n, n + 1, 0);
      n++;
    end
    send(REQ_ADD, 5, 6, 0);               // store full
    send(REQ_ADD, 1023, 0, 0);
    send(REQ_BUILD, 0, 0, 0);
    for (int i = 0; i < 80; i++) begin
      if (i % 4 == 0) send(REQ_QUERY, $urandom_range(0, n), 0, $urandom_range(0, 2047));
      else if (i % 4 == 1) send(REQ_QUERY, 0, n, $urandom_range(0, n));
      else query_any();
    end

    // drain, then allow a short tail for stray strobes
    start = 0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);

    $display("Covered %0d requests over %0d node-count settings, deep chain of %0d",
             requests, settings, n);
    $display("edges and a full edge store; %0d results checked.", checked);
    if (errors == 0)
      $display("PASS tree_binary_lifting_jump");
    else
      $display("FAIL tree_binary_lifting_jump");
    $finish;
  end

endmodule
